>>> hw/rtl/cubic_trajectory_pd_tracker_defines.svh
// Assertion macros used by the tracker sequencer.
`ifndef CUBIC_TRAJECTORY_PD_TRACKER_DEFINES_SVH
`define CUBIC_TRAJECTORY_PD_TRACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CTPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctpd same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CTPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctpd next-cycle check failed");

`endif

>>> hw/rtl/ctpd_pkg.sv
// Shared types and constants of the cubic trajectory PD tracker.
package ctpd_pkg;

  localparam int Joints = 3;
  localparam int JidxW = (Joints > 1) ? $clog2(Joints) : 1;
  localparam int FracBitsDefault = 16;
  localparam int CfgIdxW = 3;
  localparam int RegW = 31;

  localparam int CFG_KP = 0;
  localparam int CFG_KV = 1;
  localparam int CFG_VEL0 = 2;
  localparam int CFG_ACC0 = 2 + Joints;

  localparam logic [63:0] TimeMax = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] Lim62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Sat60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] CoefMax = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] CoefMaxDiv3 = CoefMax / 3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_DIV_T1,
    OP_TMAX_Q,
    OP_DIV_R,
    OP_SQRT,
    OP_TMAX_S,
    OP_TSQ,
    OP_COEF_ZERO,
    OP_DIV_V,
    OP_QUAD,
    OP_DIV_C,
    OP_CUBIC,
    OP_FIN_START,
    OP_MUL,
    OP_ERR,
    OP_TAU,
    OP_PUBLISH
  } op_t;

  typedef enum logic [2:0] {
    MS_A2T,
    MS_A3T,
    MS_A3T2,
    MS_P1,
    MS_P2,
    MS_EP,
    MS_EV
  } msel_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic mul_done;
    logic last_joint;
    logic t_zero;
    logic out_busy;
  } sts_t;

endpackage

>>> hw/rtl/ctpd_div.sv
// Restoring divider, one quotient bit per cycle, saturated quotient.
module ctpd_div #(
  parameter int NW = 64 + ctpd_pkg::FracBitsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] n,
  input  logic [63:0]   d,
  input  logic [63:0]   lim,
  output logic          done,
  output logic [63:0]   q
);

  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] nsh;
  logic [63:0]   rem;
  logic [NW-1:0] quo;
  logic [63:0]   dd;
  logic [63:0]   ll;

  logic [64:0]   r1;
  logic          ge;
  logic [64:0]   rdiff;
  logic [NW-1:0] quo_next;

  assign r1 = {rem, nsh[NW-1]};
  assign ge = r1 >= {1'b0, dd};
  assign rdiff = r1 - {1'b0, dd};
  assign quo_next = {quo[NW-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= n;
      rem <= '0;
      quo <= '0;
      dd <= d;
      ll <= lim;
    end else if (busy) begin
      nsh <= {nsh[NW-2:0], 1'b0};
      rem <= ge ? rdiff[63:0] : r1[63:0];
      quo <= quo_next;
      if (cnt == '0) begin
        q <= (quo_next > NW'(ll)) ? ll : quo_next[63:0];
      end
    end
  end

endmodule

>>> hw/rtl/ctpd_sqrt.sv
// Integer square root, two radicand bits per cycle.
module ctpd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] xr;
  logic [63:0] res;
  logic [63:0] bitv;

  logic [63:0] sum;
  logic        take;
  logic [63:0] res_next;

  assign sum = res + bitv;
  assign take = xr >= sum;
  assign res_next = take ? ((res >> 1) + bitv) : (res >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x;
      res <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (take) begin
        xr <= xr - sum;
      end
      res <= res_next;
      bitv <= bitv >> 2;
      if (cnt == '0) begin
        root <= res_next[31:0];
      end
    end
  end

endmodule

>>> hw/rtl/ctpd_mul.sv
// Signed by unsigned fixed-point multiply in two 32-bit partial products.
module ctpd_mul #(
  parameter int FRAC_BITS = ctpd_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] x,
  input  logic        [31:0] u,
  output logic               done,
  output logic signed [63:0] p
);

  logic        busy;
  logic [1:0]  cnt;
  logic        sgn;
  logic [62:0] a;
  logic [31:0] ub;
  logic [63:0] plo;
  logic [62:0] phi;

  logic [63:0] xabs;
  logic [94:0] full;
  logic [94:0] qf;
  logic [63:0] mag;

  assign xabs = x[63] ? (64'd0 - x) : x;
  assign full = {phi, 32'd0} + {31'd0, plo};
  assign qf = full >> FRAC_BITS;
  assign mag = (qf > 95'(Sat60)) ? Sat60 : qf[63:0];

  localparam logic [63:0] Sat60 = ctpd_pkg::Sat60;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sgn <= x[63];
      a <= xabs[62:0];
      ub <= u;
    end else if (busy) begin
      case (cnt)
        2'd0: plo <= a[31:0] * ub;
        2'd1: phi <= a[62:32] * ub;
        default: p <= sgn ? -$signed(mag) : $signed(mag);
      endcase
    end
  end

endmodule

>>> hw/rtl/ctpd_ctrl.sv
// Sequencer of the tracker: walks joints through the start and tick flows.
`include "cubic_trajectory_pd_tracker_defines.svh"

module ctpd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             action,
  output logic             in_ready,
  input  ctpd_pkg::sts_t   sts,
  output ctpd_pkg::cmd_t   cmd
);

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_DIFF = 20'h00002,
    ST_T1   = 20'h00004,
    ST_T1W  = 20'h00008,
    ST_R    = 20'h00010,
    ST_RW   = 20'h00020,
    ST_SQ   = 20'h00040,
    ST_SQW  = 20'h00080,
    ST_TSQ  = 20'h00100,
    ST_ZERO = 20'h00200,
    ST_V    = 20'h00400,
    ST_VW   = 20'h00800,
    ST_C    = 20'h01000,
    ST_CW   = 20'h02000,
    ST_FIN  = 20'h04000,
    ST_MUL  = 20'h08000,
    ST_MULW = 20'h10000,
    ST_ERR  = 20'h20000,
    ST_TAU  = 20'h40000,
    ST_OUT  = 20'h80000
  } state_t;

  state_t state, state_next;
  ctpd_pkg::msel_t step, step_next;

  function automatic ctpd_pkg::msel_t succ(input ctpd_pkg::msel_t s);
    ctpd_pkg::msel_t r;
    case (s)
      ctpd_pkg::MS_A2T:  r = ctpd_pkg::MS_A3T;
      ctpd_pkg::MS_A3T:  r = ctpd_pkg::MS_A3T2;
      ctpd_pkg::MS_A3T2: r = ctpd_pkg::MS_P1;
      ctpd_pkg::MS_P1:   r = ctpd_pkg::MS_P2;
      ctpd_pkg::MS_P2:   r = ctpd_pkg::MS_EP;
      ctpd_pkg::MS_EP:   r = ctpd_pkg::MS_EV;
      default:           r = ctpd_pkg::MS_A2T;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= ctpd_pkg::MS_A2T;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    cmd.op = ctpd_pkg::OP_NONE;
    cmd.msel = step;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = ctpd_pkg::OP_LOAD;
          step_next = ctpd_pkg::MS_A2T;
          state_next = action ? ST_MUL : ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.op = ctpd_pkg::OP_DIFF;
        state_next = ST_T1;
      end
      ST_T1: begin
        cmd.op = ctpd_pkg::OP_DIV_T1;
        state_next = ST_T1W;
      end
      ST_T1W: begin
        if (sts.div_done) begin
          cmd.op = ctpd_pkg::OP_TMAX_Q;
          state_next = ST_R;
        end
      end
      ST_R: begin
        cmd.op = ctpd_pkg::OP_DIV_R;
        state_next = ST_RW;
      end
      ST_RW: begin
        if (sts.div_done) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.op = ctpd_pkg::OP_SQRT;
        state_next = ST_SQW;
      end
      ST_SQW: begin
        if (sts.sqrt_done) begin
          cmd.op = ctpd_pkg::OP_TMAX_S;
          state_next = sts.last_joint ? ST_TSQ : ST_DIFF;
        end
      end
      ST_TSQ: begin
        cmd.op = ctpd_pkg::OP_TSQ;
        state_next = sts.t_zero ? ST_ZERO : ST_V;
      end
      ST_ZERO: begin
        cmd.op = ctpd_pkg::OP_COEF_ZERO;
        if (sts.last_joint) begin
          state_next = ST_FIN;
        end
      end
      ST_V: begin
        cmd.op = ctpd_pkg::OP_DIV_V;
        state_next = ST_VW;
      end
      ST_VW: begin
        if (sts.div_done) begin
          cmd.op = ctpd_pkg::OP_QUAD;
          state_next = ST_C;
        end
      end
      ST_C: begin
        cmd.op = ctpd_pkg::OP_DIV_C;
        state_next = ST_CW;
      end
      ST_CW: begin
        if (sts.div_done) begin
          cmd.op = ctpd_pkg::OP_CUBIC;
          state_next = sts.last_joint ? ST_FIN : ST_V;
        end
      end
      ST_FIN: begin
        cmd.op = ctpd_pkg::OP_FIN_START;
        state_next = ST_OUT;
      end
      ST_MUL: begin
        cmd.op = ctpd_pkg::OP_MUL;
        state_next = ST_MULW;
      end
      ST_MULW: begin
        if (sts.mul_done) begin
          step_next = succ(step);
          case (step)
            ctpd_pkg::MS_P2: state_next = ST_ERR;
            ctpd_pkg::MS_EV: state_next = ST_TAU;
            default:         state_next = ST_MUL;
          endcase
        end
      end
      ST_ERR: begin
        cmd.op = ctpd_pkg::OP_ERR;
        state_next = ST_MUL;
      end
      ST_TAU: begin
        cmd.op = ctpd_pkg::OP_TAU;
        state_next = sts.last_joint ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.op = ctpd_pkg::OP_PUBLISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `CTPD_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
  `CTPD_ASSERT_NEXT(a_publish_idle, (state == ST_OUT) && !sts.out_busy, state == ST_IDLE)
  `CTPD_ASSERT_NEXT(a_ev_to_tau, (state == ST_MULW) && sts.mul_done && (step == ctpd_pkg::MS_EV), state == ST_TAU)

endmodule

>>> hw/rtl/ctpd_dp.sv
// Datapath of the tracker: registers, trajectory state and arithmetic units.
module ctpd_dp #(
  parameter int FRAC_BITS = ctpd_pkg::FracBitsDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ctpd_pkg::cmd_t                       cmd,
  output ctpd_pkg::sts_t                       sts,
  input  logic                          [31:0] now_in,
  input  logic signed                   [31:0] pos_in [ctpd_pkg::Joints],
  input  logic signed                   [31:0] rt_in [ctpd_pkg::Joints],
  input  logic signed                   [31:0] grv_in [ctpd_pkg::Joints],
  input  logic                                 cfg_we,
  input  logic [ctpd_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ctpd_pkg::RegW-1:0]            cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed                   [31:0] out_tq [ctpd_pkg::Joints],
  output logic                                 out_trk,
  output logic                          [31:0] out_end
);

  localparam int J = ctpd_pkg::Joints;
  localparam int JW = ctpd_pkg::JidxW;
  localparam int RW = ctpd_pkg::RegW;
  localparam int NW = 64 + FRAC_BITS;
  localparam logic [RW-1:0] LimReset = RW'(1) << FRAC_BITS;

  logic [31:0]        now_r;
  logic signed [31:0] pos_r [J];
  logic signed [31:0] rt_r [J];
  logic signed [31:0] grv_r [J];

  logic [RW-1:0] kp, kv;
  logic [RW-1:0] vel_lim [J];
  logic [RW-1:0] acc_lim [J];

  logic [31:0]        start_time, end_time;
  logic signed [31:0] start_ang [J];
  logic signed [47:0] quad [J];
  logic signed [47:0] cubic [J];
  logic [32:0]        mag [J];
  logic               neg [J];

  logic [JW-1:0]      j;
  logic [31:0]        tmove;
  logic [63:0]        tsq;
  logic               sq_big;
  logic [62:0]        vreg;
  logic signed [63:0] a2t, a3t, a3t2, p1, p2, ep, ev, e1, e2;
  logic signed [31:0] tau_w [J];
  logic               trk_w;
  ctpd_pkg::msel_t    mul_dst;

  logic               last_j;
  logic [RW-1:0]      vm, am;
  logic signed [32:0] diff;
  logic [63:0]        mag64, m3;
  logic [NW-1:0]      div_n;
  logic [63:0]        div_d, div_lim, div_q;
  logic               div_start, div_done;
  logic [63:0]        sq_x;
  logic               sq_done;
  logic [31:0]        sq_root, sq_cand;
  logic signed [63:0] mul_x, mul_p;
  logic [31:0]        mul_u, tnow;
  logic               mul_done, track;
  logic [46:0]        qm;
  logic [63:0]        v3;
  logic signed [63:0] sum;
  logic signed [31:0] sat32;
  logic [32:0]        end_sum;

  assign last_j = (j == JW'(J - 1));
  assign vm = (vel_lim[j] == '0) ? RW'(1) : vel_lim[j];
  assign am = (acc_lim[j] == '0) ? RW'(1) : acc_lim[j];
  assign diff = {rt_r[j][31], rt_r[j]} - {pos_r[j][31], pos_r[j]};
  assign mag64 = 64'(mag[j]);
  assign m3 = mag64 + (mag64 << 1);
  assign tnow = now_r - start_time;
  assign track = (now_r >= start_time) && (now_r <= end_time);
  assign v3 = div_q + (div_q << 1);
  assign qm = (div_q > ctpd_pkg::CoefMaxDiv3) ? ctpd_pkg::CoefMax[46:0] : v3[46:0];
  assign sq_x = div_q << FRAC_BITS;
  assign sq_cand = sq_big ? 32'hFFFF_FFFF : sq_root;
  assign end_sum = {1'b0, now_r} + {1'b0, tmove};

  always_comb begin
    div_start = 1'b1;
    div_n = '0;
    div_d = '0;
    div_lim = '0;
    case (cmd.op)
      ctpd_pkg::OP_DIV_T1: begin
        div_n = NW'(m3) << FRAC_BITS;
        div_d = 64'({vm, 1'b0});
        div_lim = ctpd_pkg::TimeMax;
      end
      ctpd_pkg::OP_DIV_R: begin
        div_n = NW'(m3 << 1) << FRAC_BITS;
        div_d = 64'(am);
        div_lim = ctpd_pkg::Lim62;
      end
      ctpd_pkg::OP_DIV_V: begin
        div_n = NW'(mag64) << (2 * FRAC_BITS);
        div_d = tsq;
        div_lim = ctpd_pkg::Lim62;
      end
      ctpd_pkg::OP_DIV_C: begin
        div_n = NW'({vreg, 1'b0}) << FRAC_BITS;
        div_d = 64'(tmove);
        div_lim = ctpd_pkg::CoefMax;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    mul_u = tnow;
    case (cmd.msel)
      ctpd_pkg::MS_A2T:  mul_x = {{16{quad[j][47]}}, quad[j]};
      ctpd_pkg::MS_A3T:  mul_x = {{16{cubic[j][47]}}, cubic[j]};
      ctpd_pkg::MS_A3T2: mul_x = a3t;
      ctpd_pkg::MS_P1:   mul_x = a2t;
      ctpd_pkg::MS_P2:   mul_x = a3t2;
      ctpd_pkg::MS_EP: begin
        mul_x = ep;
        mul_u = {1'b0, kp};
      end
      ctpd_pkg::MS_EV: begin
        mul_x = ev;
        mul_u = {1'b0, kv};
      end
      default: mul_x = '0;
    endcase
  end

  always_comb begin
    sum = {{32{grv_r[j][31]}}, grv_r[j]} + (track ? (e1 + e2) : 64'sd0);
    if (sum > 64'sh7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (sum < -64'sh8000_0000) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = sum[31:0];
    end
  end

  ctpd_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .lim   (div_lim),
    .done  (div_done),
    .q     (div_q)
  );

  ctpd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == ctpd_pkg::OP_SQRT),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  ctpd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == ctpd_pkg::OP_MUL),
    .x     (mul_x),
    .u     (mul_u),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign sts.div_done = div_done;
  assign sts.sqrt_done = sq_done;
  assign sts.mul_done = mul_done;
  assign sts.last_joint = last_j;
  assign sts.t_zero = (tmove == '0);
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0;
      kv <= '0;
      start_time <= '0;
      end_time <= '0;
      out_valid <= 1'b0;
      j <= '0;
      for (int k = 0; k < J; k++) begin
        vel_lim[k] <= LimReset;
        acc_lim[k] <= LimReset;
        start_ang[k] <= '0;
        quad[k] <= '0;
        cubic[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == ctpd_pkg::CfgIdxW'(ctpd_pkg::CFG_KP)) begin
          kp <= cfg_data;
        end
        if (cfg_index == ctpd_pkg::CfgIdxW'(ctpd_pkg::CFG_KV)) begin
          kv <= cfg_data;
        end
        for (int k = 0; k < J; k++) begin
          if (cfg_index == ctpd_pkg::CfgIdxW'(ctpd_pkg::CFG_VEL0 + k)) begin
            vel_lim[k] <= cfg_data;
          end
          if (cfg_index == ctpd_pkg::CfgIdxW'(ctpd_pkg::CFG_ACC0 + k)) begin
            acc_lim[k] <= cfg_data;
          end
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        ctpd_pkg::OP_LOAD: j <= '0;
        ctpd_pkg::OP_DIFF: start_ang[j] <= pos_r[j];
        ctpd_pkg::OP_TMAX_S, ctpd_pkg::OP_TAU: j <= last_j ? '0 : j + 1'b1;
        ctpd_pkg::OP_COEF_ZERO: begin
          quad[j] <= '0;
          cubic[j] <= '0;
          j <= last_j ? '0 : j + 1'b1;
        end
        ctpd_pkg::OP_QUAD: quad[j] <= neg[j] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        ctpd_pkg::OP_CUBIC: begin
          cubic[j] <= neg[j] ? $signed({1'b0, div_q[46:0]}) : -$signed({1'b0, div_q[46:0]});
          j <= last_j ? '0 : j + 1'b1;
        end
        ctpd_pkg::OP_FIN_START: begin
          start_time <= now_r;
          end_time <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
        end
        ctpd_pkg::OP_PUBLISH: out_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (mul_dst)
        ctpd_pkg::MS_A2T:  a2t <= mul_p;
        ctpd_pkg::MS_A3T:  a3t <= mul_p;
        ctpd_pkg::MS_A3T2: a3t2 <= mul_p;
        ctpd_pkg::MS_P1:   p1 <= mul_p;
        ctpd_pkg::MS_P2:   p2 <= mul_p;
        ctpd_pkg::MS_EP:   e1 <= mul_p;
        default:           e2 <= mul_p;
      endcase
    end
    case (cmd.op)
      ctpd_pkg::OP_LOAD: begin
        now_r <= now_in;
        tmove <= '0;
        for (int k = 0; k < J; k++) begin
          pos_r[k] <= pos_in[k];
          rt_r[k] <= rt_in[k];
          grv_r[k] <= grv_in[k];
        end
      end
      ctpd_pkg::OP_DIFF: begin
        neg[j] <= diff[32];
        mag[j] <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      ctpd_pkg::OP_TMAX_Q: begin
        if (div_q[31:0] > tmove) begin
          tmove <= div_q[31:0];
        end
      end
      ctpd_pkg::OP_SQRT: sq_big <= (div_q >> (64 - FRAC_BITS)) != '0;
      ctpd_pkg::OP_TMAX_S: begin
        if (sq_cand > tmove) begin
          tmove <= sq_cand;
        end
      end
      ctpd_pkg::OP_TSQ: tsq <= tmove * tmove;
      ctpd_pkg::OP_QUAD: vreg <= div_q[62:0];
      ctpd_pkg::OP_FIN_START: begin
        trk_w <= 1'b0;
        for (int k = 0; k < J; k++) begin
          tau_w[k] <= '0;
        end
      end
      ctpd_pkg::OP_MUL: mul_dst <= cmd.msel;
      ctpd_pkg::OP_ERR: begin
        ep <= {{32{start_ang[j][31]}}, start_ang[j]} + p1 + p2
              - {{32{pos_r[j][31]}}, pos_r[j]};
        ev <= (a2t <<< 1) + a3t2 + (a3t2 <<< 1) - {{32{rt_r[j][31]}}, rt_r[j]};
      end
      ctpd_pkg::OP_TAU: begin
        tau_w[j] <= sat32;
        trk_w <= track;
      end
      ctpd_pkg::OP_PUBLISH: begin
        out_trk <= trk_w;
        out_end <= end_time;
        for (int k = 0; k < J; k++) begin
          out_tq[k] <= tau_w[k];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/cubic_trajectory_pd_tracker.sv
// Top level of the three-joint cubic trajectory PD tracker.
// One beat is taken at a time. A start beat (action 0) plans the move: per
// joint two divides and one square root, then per joint two more divides
// (none if the move time is zero) on the shared restoring divider and the
// square root unit; it answers with zero torques and the new end time. A tick
// beat (action 1) runs seven products per joint on the shared two-pass 32x32
// multiplier. The result waits in an output register, so the next beat is
// taken while it is still unread, and a new result is held back until the
// old one is taken.
module cubic_trajectory_pd_tracker #(
  parameter int FRAC_BITS = ctpd_pkg::FracBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic                  [31:0] now_time,
  input  logic signed           [31:0] position_j0,
  input  logic signed           [31:0] position_j1,
  input  logic signed           [31:0] position_j2,
  input  logic signed           [31:0] rate_or_target_j0,
  input  logic signed           [31:0] rate_or_target_j1,
  input  logic signed           [31:0] rate_or_target_j2,
  input  logic signed           [31:0] gravity_j0,
  input  logic signed           [31:0] gravity_j1,
  input  logic signed           [31:0] gravity_j2,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed           [31:0] torque_j0,
  output logic signed           [31:0] torque_j1,
  output logic signed           [31:0] torque_j2,
  output logic                         tracking,
  output logic                  [31:0] end_time,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ctpd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ctpd_pkg::RegW-1:0]    cfg_data
);

  ctpd_pkg::cmd_t cmd;
  ctpd_pkg::sts_t sts;

  logic signed [31:0] pos_a [ctpd_pkg::Joints];
  logic signed [31:0] rt_a [ctpd_pkg::Joints];
  logic signed [31:0] grv_a [ctpd_pkg::Joints];
  logic signed [31:0] tq_a [ctpd_pkg::Joints];

  assign pos_a[0] = position_j0;
  assign pos_a[1] = position_j1;
  assign pos_a[2] = position_j2;
  assign rt_a[0] = rate_or_target_j0;
  assign rt_a[1] = rate_or_target_j1;
  assign rt_a[2] = rate_or_target_j2;
  assign grv_a[0] = gravity_j0;
  assign grv_a[1] = gravity_j1;
  assign grv_a[2] = gravity_j2;
  assign torque_j0 = tq_a[0];
  assign torque_j1 = tq_a[1];
  assign torque_j2 = tq_a[2];
  assign cfg_ready = 1'b1;

  ctpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctpd_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .now_in    (now_time),
    .pos_in    (pos_a),
    .rt_in     (rt_a),
    .grv_in    (grv_a),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_tq    (tq_a),
    .out_trk   (tracking),
    .out_end   (end_time)
  );

endmodule

>>> verif/cubic_trajectory_pd_tracker_test.sv
// Self-checking testbench of the cubic trajectory PD tracker, with its own torque predictor.
module cubic_trajectory_pd_tracker_test;
  import ctpd_pkg::*;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam logic [63:0] W32 = 64'hFFFF_FFFF;
  localparam int FRAC = 16;

  typedef struct {
    logic               action;
    logic        [31:0] now;
    logic signed [31:0] pos[3];
    logic signed [31:0] rt[3];
    logic signed [31:0] grav[3];
  } servo_beat_t;

  typedef struct {
    logic signed [31:0] torque[3];
    logic               tracking;
    logic        [31:0] end_t;
  } drive_t;

  typedef struct {
    logic [30:0] kp;
    logic [30:0] kv;
    logic [30:0] vel[3];
    logic [30:0] acc[3];
  } tuning_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic [31:0] now_time = '0;
  logic signed [31:0] position_j0 = '0, position_j1 = '0, position_j2 = '0;
  logic signed [31:0] rate_or_target_j0 = '0, rate_or_target_j1 = '0, rate_or_target_j2 = '0;
  logic signed [31:0] gravity_j0 = '0, gravity_j1 = '0, gravity_j2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] torque_j0, torque_j1, torque_j2;
  logic tracking;
  logic [31:0] end_time;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [RegW-1:0] cfg_data = '0;

  cubic_trajectory_pd_tracker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .now_time(now_time),
    .position_j0(position_j0), .position_j1(position_j1), .position_j2(position_j2),
    .rate_or_target_j0(rate_or_target_j0), .rate_or_target_j1(rate_or_target_j1),
    .rate_or_target_j2(rate_or_target_j2),
    .gravity_j0(gravity_j0), .gravity_j1(gravity_j1), .gravity_j2(gravity_j2),
    .out_valid(out_valid), .out_ready(out_ready),
    .torque_j0(torque_j0), .torque_j1(torque_j1), .torque_j2(torque_j2),
    .tracking(tracking), .end_time(end_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tracker state mirror
  logic [63:0] m_kp, m_kv;
  logic [63:0] m_vel[3], m_acc[3];
  logic [63:0] m_start, m_end;
  longint m_angle[3], m_quad[3], m_cubic[3];

  drive_t drive_due[$];
  int fails = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_span = 0;
  int hold_cnt = 0;

  function automatic logic [63:0] div_floor_sat(logic [63:0] n, int s, logic [63:0] d,
                                                logic [63:0] lim);
    logic [63:0] r, q, b;
    logic carry;
    r = '0;
    q = '0;
    if (d == 0) return lim;
    for (int i = 63 + s; i >= 0; i--) begin
      carry = r[63];
      b = (i >= s && i - s < 64) ? ((n >> (i - s)) & 64'd1) : 64'd0;
      r = (r << 1) | b;
      if (carry || r >= d) begin
        r = r - d;
        if (i >= 63) return lim;
        q[i] = 1'b1;
      end
    end
    return (q > lim) ? lim : q;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] res, bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x = x - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mul_mag(logic [63:0] a, logic [63:0] t);
    logic [63:0] hi, res;
    t = t & W32;
    hi = (a >> 32) * t;
    if ((hi >> (28 + FRAC)) != 0) return Sat60;
    res = (hi << (32 - FRAC)) + (((a & W32) * t) >> FRAC);
    return (res > Sat60) ? Sat60 : res;
  endfunction

  function automatic longint mul_signed(longint a, logic [63:0] t);
    logic [63:0] m;
    m = mul_mag((a < 0) ? -a : a, t);
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic drive_t predict_drive(servo_beat_t b);
    drive_t r;
    logic [63:0] mag[3], tm, t1, t2, rr, v, qm, cm, sum, tt;
    logic neg[3];
    longint d, tau, a2t, a3t2, qref, vref;
    logic trk;
    if (b.action == ACT_START) begin
      tm = '0;
      for (int j = 0; j < 3; j++) begin
        d = longint'(b.rt[j]) - longint'(b.pos[j]);
        neg[j] = d < 0;
        mag[j] = (d < 0) ? -d : d;
        m_angle[j] = b.pos[j];
        t1 = div_floor_sat(3 * mag[j], FRAC, 2 * ((m_vel[j] == 0) ? 64'd1 : m_vel[j]), TimeMax);
        rr = div_floor_sat(6 * mag[j], FRAC, (m_acc[j] == 0) ? 64'd1 : m_acc[j], Lim62);
        t2 = ((rr >> (64 - FRAC)) != 0) ? TimeMax : root_floor(rr << FRAC);
        if (t2 > TimeMax) t2 = TimeMax;
        if (t1 > tm) tm = t1;
        if (t2 > tm) tm = t2;
      end
      for (int j = 0; j < 3; j++) begin
        qm = '0;
        cm = '0;
        if (tm != 0) begin
          v = div_floor_sat(mag[j], 2 * FRAC, tm * tm, Lim62);
          qm = (v > CoefMaxDiv3) ? CoefMax : 3 * v;
          cm = div_floor_sat(2 * v, FRAC, tm, CoefMax);
        end
        m_quad[j] = neg[j] ? -longint'(qm) : longint'(qm);
        m_cubic[j] = neg[j] ? longint'(cm) : -longint'(cm);
        r.torque[j] = '0;
      end
      sum = {32'd0, b.now} + tm;
      m_start = {32'd0, b.now};
      m_end = (sum > TimeMax) ? TimeMax : sum;
      r.tracking = 1'b0;
      r.end_t = m_end[31:0];
      return r;
    end
    trk = ({32'd0, b.now} >= m_start) && ({32'd0, b.now} <= m_end);
    tt = ({32'd0, b.now} - m_start) & W32;
    for (int j = 0; j < 3; j++) begin
      tau = b.grav[j];
      if (trk) begin
        a2t = mul_signed(m_quad[j], tt);
        a3t2 = mul_signed(mul_signed(m_cubic[j], tt), tt);
        qref = m_angle[j] + mul_signed(a2t, tt) + mul_signed(a3t2, tt);
        vref = 2 * a2t + 3 * a3t2;
        tau = tau + mul_signed(qref - longint'(b.pos[j]), m_kp)
            + mul_signed(vref - longint'(b.rt[j]), m_kv);
      end
      if (tau > 64'sd2147483647) tau = 64'sd2147483647;
      if (tau < -64'sd2147483648) tau = -64'sd2147483648;
      r.torque[j] = tau[31:0];
    end
    r.tracking = trk;
    r.end_t = m_end[31:0];
    return r;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    drive_t e;
    if (hold_cnt < hold_span) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (!rst && out_valid && out_ready) begin
      if (drive_due.size() == 0) begin
        $error("unexpected result beat");
        fails++;
      end else begin
        e = drive_due.pop_front();
        if (torque_j0 !== e.torque[0]) begin
          $error("torque_j0 exp %0d got %0d", e.torque[0], torque_j0);
          fails++;
        end
        if (torque_j1 !== e.torque[1]) begin
          $error("torque_j1 exp %0d got %0d", e.torque[1], torque_j1);
          fails++;
        end
        if (torque_j2 !== e.torque[2]) begin
          $error("torque_j2 exp %0d got %0d", e.torque[2], torque_j2);
          fails++;
        end
        if (tracking !== e.tracking) begin
          $error("tracking exp %0d got %0d", e.tracking, tracking);
          fails++;
        end
        if (end_time !== e.end_t) begin
          $error("end_time exp %0h got %0h", e.end_t, end_time);
          fails++;
        end
      end
    end
  end

  task automatic send_beat(servo_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= b.action;
    now_time <= b.now;
    position_j0 <= b.pos[0];
    position_j1 <= b.pos[1];
    position_j2 <= b.pos[2];
    rate_or_target_j0 <= b.rt[0];
    rate_or_target_j1 <= b.rt[1];
    rate_or_target_j2 <= b.rt[2];
    gravity_j0 <= b.grav[0];
    gravity_j1 <= b.grav[1];
    gravity_j2 <= b.grav[2];
    do @(posedge clk); while (!in_ready);
    drive_due.push_back(predict_drive(b));
  endtask

  task automatic send_start(logic [31:0] now, logic signed [31:0] p0, p1, p2, g0, g1, g2);
    servo_beat_t b;
    b.action = ACT_START;
    b.now = now;
    b.pos = '{p0, p1, p2};
    b.rt = '{g0, g1, g2};
    b.grav = '{$urandom, $urandom, $urandom};
    send_beat(b);
  endtask

  task automatic send_tick(logic [31:0] now, logic signed [31:0] p0, p1, p2, r0, r1, r2,
                           g0, g1, g2);
    servo_beat_t b;
    b.action = ACT_TICK;
    b.now = now;
    b.pos = '{p0, p1, p2};
    b.rt = '{r0, r1, r2};
    b.grav = '{g0, g1, g2};
    send_beat(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  task automatic load_tuning(tuning_t c);
    logic [30:0] vals[8];
    wait_drained();
    vals = '{c.kp, c.kv, c.vel[0], c.vel[1], c.vel[2], c.acc[0], c.acc[1], c.acc[2]};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      if (i == CFG_KP) m_kp = vals[i];
      else if (i == CFG_KV) m_kv = vals[i];
      else if (i < CFG_ACC0) m_vel[i - CFG_VEL0] = vals[i];
      else m_acc[i - CFG_ACC0] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_angle();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 1 << 19)) - 32'sd262144;
    endcase
  endfunction

  function automatic logic [30:0] pick_gain();
    case ($urandom_range(5))
      0: return $urandom;
      1: return '0;
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(0, 4);
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  function automatic logic [31:0] pick_tick_time();
    logic [63:0] span, off;
    span = m_end - m_start;
    case ($urandom_range(9))
      0: return m_start - $urandom_range(1, 1000);
      1: return m_end + $urandom_range(1, 1000);
      2: return $urandom;
      3: return m_end;
      default: begin
        off = {$urandom, $urandom} % (span + 1);
        return m_start + off;
      end
    endcase
  endfunction

  task automatic random_tick(logic [31:0] now);
    send_tick(now, pick_angle(), pick_angle(), pick_angle(),
              pick_angle(), pick_angle(), pick_angle(),
              pick_angle(), pick_angle(), pick_angle());
  endtask

  task automatic test_reset_hold();
    send_tick(0, 0, 0, 0, 0, 0, 0, 32'sd100, -32'sd100, 32'sd7);
    send_tick(5, 32'sd9, 0, 0, 0, 0, 0, 32'sd1, 32'sd2, 32'sd3);
  endtask

  task automatic test_directed();
    tuning_t c;
    c.kp = 31'h10000;
    c.kv = 31'h8000;
    c.vel = '{31'h10000, 31'h20000, 31'h8000};
    c.acc = '{31'h10000, 31'h4000, 31'h30000};
    load_tuning(c);
    send_start(32'h10000, 0, 0, 0, 32'sh10000, -32'sh20000, 32'sh8000);
    send_tick(m_start, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tick(m_start + (m_end - m_start) / 2, 32'sh100, -32'sh100, 0, 32'sh40, 0, 0, 5, 6, 7);
    send_tick(m_end, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tick(m_end + 1, 0, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_tick(m_start - 1, 0, 0, 0, 0, 0, 0, 1, 1, 1);
    // zero move: coefficients stay zero
    send_start(5, 7, 7, 7, 7, 7, 7);
    send_tick(5, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 2, 2, 2);
    send_tick(6, 0, 0, 0, 0, 0, 0, 2, 2, 2);
    // full-scale move, end time saturates
    send_start(32'hFFFF_FFF0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF,
               32'sh8000_0000, -32'sd1);
    send_tick(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000,
              32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    c.kp = 31'h7FFF_FFFF;
    c.kv = 31'h7FFF_FFFF;
    c.vel = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    c.acc = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    load_tuning(c);
    send_start(32'd1000, 0, 0, 0, 32'sh10000, -32'sh10000, 32'sh7FFF_FFFF);
    send_tick(m_start + 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh8000_0000,
              32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_tick(m_end, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0, 0, 0, 0, 0);
    // zero limits act as one LSB
    c.vel = '{31'd0, 31'd0, 31'd0};
    c.acc = '{31'd0, 31'd0, 31'd0};
    load_tuning(c);
    send_start(32'd50, 0, 32'sd3, 0, 32'sd1, 0, -32'sd1);
    send_tick(32'd51, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tick(32'h8000_0000, 1, 1, 1, 1, 1, 1, 1, 1, 1);
  endtask

  task automatic test_backpressure();
    hold_span = hold_span + 400;
    send_start(32'd200, 0, 0, 0, 32'sh4000, 32'sh4000, -32'sh4000);
    for (int k = 0; k < 10; k++) random_tick(pick_tick_time());
    wait_drained();
  endtask

  task automatic test_random(int items);
    tuning_t c;
    int sent;
    c.kp = pick_gain();
    c.kv = pick_gain();
    for (int j = 0; j < 3; j++) begin
      c.vel[j] = pick_limit();
      c.acc[j] = pick_limit();
    end
    load_tuning(c);
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(7) == 0) begin
        random_tick($urandom);
        sent++;
      end else begin
        logic signed [31:0] p[3], g[3];
        for (int j = 0; j < 3; j++) begin
          p[j] = pick_angle();
          g[j] = ($urandom_range(9) == 0) ? p[j] : pick_angle();
        end
        send_start($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20),
                   p[0], p[1], p[2], g[0], g[1], g[2]);
        sent++;
        for (int k = $urandom_range(3, 12); k > 0; k--) begin
          random_tick(pick_tick_time());
          sent++;
        end
      end
    end
  endtask

  initial begin
    m_kp = '0;
    m_kv = '0;
    m_start = '0;
    m_end = '0;
    for (int j = 0; j < 3; j++) begin
      m_vel[j] = 64'h10000;
      m_acc[j] = 64'h10000;
      m_angle[j] = 0;
      m_quad[j] = 0;
      m_cubic[j] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_hold();
    test_directed();
    test_backpressure();
    send_idle_pct = 33;
    recv_idle_pct = 54;
    test_random(580);
    send_idle_pct = 54;
    recv_idle_pct = 33;
    test_random(580);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(580);
    wait_drained();
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
